/* rtl/div64_pkg.sv */
// ============================================================================
// div64_pkg
// Shared constants, request codes and the command record passed from the
// request front end to the division engine.
// ============================================================================
`default_nettype none

package div64_pkg;

    // Port width of the operand and result fields
    localparam int PORT_W     = 64;
    // Arithmetic width; operand bits above it are ignored (range 8 to 64)
    localparam int DATA_WIDTH = 64;
    // Iteration counter width, one step per quotient bit
    localparam int CNT_W      = $clog2(DATA_WIDTH);
    // Depth of the command queue between front end and engine
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Request codes
    localparam logic [1:0] REQ_UQUO = 2'd0;
    localparam logic [1:0] REQ_SQUO = 2'd1;
    localparam logic [1:0] REQ_UREM = 2'd2;
    localparam logic [1:0] REQ_SREM = 2'd3;

    // Classified division command
    typedef struct packed {
        logic                  is_rem;    // return remainder instead of quotient
        logic                  neg_res;   // negate the unsigned result
        logic                  zero_div;  // divisor is zero, result is 0
        logic [DATA_WIDTH-1:0] mag_a;     // dividend magnitude
        logic [DATA_WIDTH-1:0] mag_b;     // divisor magnitude
    } t_div_cmd;

endpackage

`default_nettype wire

/* rtl/div64_front.sv */
// ============================================================================
// div64_front
// Request front end: takes a request, works out operand magnitudes and
// result sign, and holds the classified command until the queue takes it.
// ============================================================================
`default_nettype none

module div64_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [1:0]                  i_req_type,
    input  wire logic [div64_pkg::PORT_W-1:0] i_dividend,
    input  wire logic [div64_pkg::PORT_W-1:0] i_divisor,
    output logic                             o_cmd_valid,
    input  wire logic                        i_cmd_ready,
    output div64_pkg::t_div_cmd              o_cmd
);
    import div64_pkg::*;

    logic                  w_signed;
    logic                  w_is_rem;
    logic                  w_a_neg;
    logic                  w_b_neg;
    logic [DATA_WIDTH-1:0] w_a;
    logic [DATA_WIDTH-1:0] w_b;
    t_div_cmd              n_cmd;
    t_div_cmd              r_cmd;
    logic                  r_valid;
    logic                  w_take;

    // Classify the request
    always_comb begin
        w_a      = i_dividend[DATA_WIDTH-1:0];
        w_b      = i_divisor[DATA_WIDTH-1:0];
        w_signed = (i_req_type == REQ_SQUO) || (i_req_type == REQ_SREM);
        w_is_rem = (i_req_type == REQ_UREM) || (i_req_type == REQ_SREM);
        w_a_neg  = w_signed & w_a[DATA_WIDTH-1];
        w_b_neg  = w_signed & w_b[DATA_WIDTH-1];

        n_cmd.is_rem   = w_is_rem;
        n_cmd.neg_res  = w_is_rem ? w_a_neg : (w_a_neg ^ w_b_neg);
        n_cmd.zero_div = (w_b == '0);
        n_cmd.mag_a    = w_a_neg ? (~w_a + 1'b1) : w_a;
        n_cmd.mag_b    = w_b_neg ? (~w_b + 1'b1) : w_b;
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign w_take      = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Hold the command until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
        if (w_take) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

/* rtl/div64_queue.sv */
// ============================================================================
// div64_queue
// Short command queue between the front end and the division engine.
// ============================================================================
`default_nettype none

module div64_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push_valid,
    output logic                     o_push_ready,
    input  wire div64_pkg::t_div_cmd i_push_cmd,
    output logic                     o_pop_valid,
    input  wire logic                i_pop_ready,
    output div64_pkg::t_div_cmd      o_pop_cmd
);
    import div64_pkg::*;

    t_div_cmd           r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_push;
    logic               w_pop;

    assign o_push_ready = (r_count != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count exceeds depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

/* rtl/div64_engine.sv */
// ============================================================================
// div64_engine
// Division engine: radix-2 restoring division, one quotient bit per cycle,
// followed by sign and zero-divisor correction into an output register.
// ============================================================================
`default_nettype none

module div64_engine (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    output logic                              o_cmd_ready,
    input  wire div64_pkg::t_div_cmd          i_cmd,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [div64_pkg::PORT_W-1:0]      o_result
);
    import div64_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIX
    } t_state;

    t_state                r_state;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_div;
    logic                  r_is_rem;
    logic                  r_neg;
    logic                  r_zero;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_res;

    logic [DATA_WIDTH:0]   w_shift;
    logic [DATA_WIDTH:0]   w_diff;
    logic                  w_fit;
    logic [DATA_WIDTH-1:0] w_val;
    logic [DATA_WIDTH-1:0] n_res;
    logic                  w_out_free;

    // One restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        w_shift = {r_rem, r_quo[DATA_WIDTH-1]};
        w_diff  = w_shift - {1'b0, r_div};
        w_fit   = !w_diff[DATA_WIDTH];
    end

    // Sign and zero-divisor correction
    always_comb begin
        w_val = r_is_rem ? r_rem : r_quo;
        if (r_zero) begin
            n_res = '0;
        end else if (r_neg) begin
            n_res = ~w_val + 1'b1;
        end else begin
            n_res = w_val;
        end
    end

    assign w_out_free  = !r_out_valid || i_ready;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_result    = PORT_W'(r_res);

    // Sequence load, iterate, correct
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_cnt    <= CNT_W'(DATA_WIDTH - 1);
                        r_rem    <= '0;
                        r_quo    <= i_cmd.mag_a;
                        r_div    <= i_cmd.mag_b;
                        r_is_rem <= i_cmd.is_rem;
                        r_neg    <= i_cmd.neg_res;
                        r_zero   <= i_cmd.zero_div;
                        r_state  <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem <= w_fit ? w_diff[DATA_WIDTH-1:0] : w_shift[DATA_WIDTH-1:0];
                    r_quo <= {r_quo[DATA_WIDTH-2:0], w_fit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    if (w_out_free) begin
                        r_res       <= n_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_valid) |=> (r_state == S_RUN &&
                                                r_cnt == CNT_W'(DATA_WIDTH - 1)))
        else $error("division did not start with full step count");

    a_out_from_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIX))
        else $error("result posted outside correction state");

    a_run_to_fix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && r_cnt == '0) |=> (r_state == S_FIX))
        else $error("iteration did not end after last step");

endmodule

`default_nettype wire

/* rtl/divider_64bit_signed_unsigned_core.sv */
// ============================================================================
// divider_64bit_signed_unsigned_core
// 64-bit signed/unsigned integer divider returning quotient or remainder.
// ============================================================================
// In the division engine each request is loaded as operand magnitudes, then
// takes one restoring step per quotient bit (64 at DATA_WIDTH = 64), then
// gets sign and zero-divisor correction into the output register once that
// register is free. The single shared subtract-and-shift step takes no new
// request until the current one has left correction. The front end and a
// two-entry command queue accept new requests while a division runs, and a
// finished result waits in the output register while the next division proceeds.
// Signed remainders take the sign of the dividend; a zero divisor gives 0;
// the most negative value divided by minus one returns itself.
// ============================================================================
`default_nettype none

module divider_64bit_signed_unsigned_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_req_type,
    input  wire logic [div64_pkg::PORT_W-1:0] i_dividend,
    input  wire logic [div64_pkg::PORT_W-1:0] i_divisor,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [div64_pkg::PORT_W-1:0]      o_result
);
    import div64_pkg::*;

    logic     w_front_valid;
    logic     w_front_ready;
    t_div_cmd w_front_cmd;
    logic     w_q_valid;
    logic     w_q_ready;
    t_div_cmd w_q_cmd;

    // Classify requests
    div64_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req_type  (i_req_type),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_cmd_valid (w_front_valid),
        .i_cmd_ready (w_front_ready),
        .o_cmd       (w_front_cmd)
    );

    // Buffer commands
    div64_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_cmd   (w_front_cmd),
        .o_pop_valid  (w_q_valid),
        .i_pop_ready  (w_q_ready),
        .o_pop_cmd    (w_q_cmd)
    );

    // Run the division
    div64_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

/* test/div64_checker.sv */
// ============================================================================
// div64_checker
// Watches the request and result channels of the 64-bit divider, computes
// the expected quotient or remainder for every accepted request and compares
// it with each accepted result, in order.
// ============================================================================
module div64_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic [1:0]                   i_req_type,
    input  logic [div64_pkg::PORT_W-1:0] i_dividend,
    input  logic [div64_pkg::PORT_W-1:0] i_divisor,
    input  logic                         i_res_valid,
    input  logic                         i_res_ready,
    input  logic [div64_pkg::PORT_W-1:0] i_result,
    output int                           o_errors,
    output int                           o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import div64_pkg::*;

    typedef struct {
        logic [1:0]        op;
        logic [PORT_W-1:0] dividend;
        logic [PORT_W-1:0] divisor;
        logic [PORT_W-1:0] value;
    } t_div_expect;

    t_div_expect pending_results[$];
    int          errors = 0;
    int          outstanding = 0;

    assign o_errors      = errors;
    assign o_outstanding = outstanding;

    // Two's complement negate, wrapped to the arithmetic width
    function automatic logic [PORT_W-1:0] negate_wrapped(input logic [PORT_W-1:0] v,
                                                         input logic [PORT_W-1:0] mask);
        return (~v + 1'b1) & mask;
    endfunction

    // Quotient or remainder of one request, signed ops on magnitudes
    function automatic logic [PORT_W-1:0] divide_result(input logic [1:0]        op,
                                                        input logic [PORT_W-1:0] dvd,
                                                        input logic [PORT_W-1:0] dvs);
        logic [PORT_W-1:0] mask;
        logic [PORT_W-1:0] sign;
        logic [PORT_W-1:0] a;
        logic [PORT_W-1:0] b;
        logic [PORT_W-1:0] mag_a;
        logic [PORT_W-1:0] mag_b;
        logic [PORT_W-1:0] quo;
        logic [PORT_W-1:0] rem;
        logic              is_signed;
        logic              is_rem;
        logic              a_neg;
        logic              b_neg;
        mask      = '1;
        mask      = mask >> (PORT_W - DATA_WIDTH);
        sign      = {{(PORT_W-1){1'b0}}, 1'b1} << (DATA_WIDTH - 1);
        a         = dvd & mask;
        b         = dvs & mask;
        is_signed = (op == REQ_SQUO) || (op == REQ_SREM);
        is_rem    = (op == REQ_UREM) || (op == REQ_SREM);
        a_neg     = is_signed && ((a & sign) != '0);
        b_neg     = is_signed && ((b & sign) != '0);
        mag_a     = a_neg ? negate_wrapped(a, mask) : a;
        mag_b     = b_neg ? negate_wrapped(b, mask) : b;
        quo       = '0;
        rem       = '0;
        // zero divisor leaves both at zero
        if (mag_b != '0) begin
            quo = mag_a / mag_b;
            rem = mag_a % mag_b;
        end
        if (is_rem) begin
            return a_neg ? negate_wrapped(rem, mask) : rem;
        end
        return (a_neg != b_neg) ? negate_wrapped(quo, mask) : quo;
    endfunction

    // Retire results before queueing new requests of the same cycle
    always @(posedge i_clk) begin
        t_div_expect exp_item;
        t_div_expect new_item;
        logic        req_xfer;
        logic        res_xfer;
        req_xfer = i_rst_n && i_req_valid && i_req_ready;
        res_xfer = i_rst_n && i_res_valid && i_res_ready;
        if (res_xfer) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result transfer with no request pending, expected none, actual %h",
                         $time, i_result);
            end else begin
                exp_item = pending_results.pop_front();
                if (exp_item.value !== i_result) begin
                    errors++;
                    $display("%0t: op %0d %h / %h: expected %h, actual %h", $time,
                             exp_item.op, exp_item.dividend, exp_item.divisor,
                             exp_item.value, i_result);
                end
            end
        end
        if (req_xfer) begin
            new_item.op       = i_req_type;
            new_item.dividend = i_dividend;
            new_item.divisor  = i_divisor;
            new_item.value    = divide_result(i_req_type, i_dividend, i_divisor);
            pending_results.push_back(new_item);
        end
        // track requests still owed a result
        outstanding <= outstanding + int'(req_xfer) - int'(res_xfer);
    end

endmodule

/* test/testbench.sv */
// ============================================================================
// testbench
// Drives requests into the 64-bit signed/unsigned divider under several
// idle and stall patterns, holds off the result side to fill the block, and
// reports the verdict from the attached checker.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import div64_pkg::*;

    localparam int PHASE_ITEMS = 500;
    localparam int LONG_HOLD   = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 150;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_valid    = 1'b0;
    logic              o_ready;
    logic [1:0]        i_req_type = REQ_UQUO;
    logic [PORT_W-1:0] i_dividend = '0;
    logic [PORT_W-1:0] i_divisor  = '0;
    logic              o_valid;
    logic              i_ready    = 1'b0;
    logic [PORT_W-1:0] o_result;

    int   errors;
    int   outstanding;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    logic hold_req     = 1'b0;
    logic hold_ack     = 1'b0;
    int   hold_left    = 0;
    int   quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    divider_64bit_signed_unsigned_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_req_type (i_req_type),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (o_result)
    );

    div64_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_req_type    (i_req_type),
        .i_dividend    (i_dividend),
        .i_divisor     (i_divisor),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_result      (o_result),
        .o_errors      (errors),
        .o_outstanding (outstanding)
    );

    // Result side: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            i_ready   <= 1'b0;
            hold_ack  <= hold_req;
            hold_left <= LONG_HOLD;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog: abort when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[divider_64bit_signed_unsigned_core] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request and hold it until the transfer
    task automatic send_item(input logic [1:0]        op,
                             input logic [PORT_W-1:0] dvd,
                             input logic [PORT_W-1:0] dvs);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= op;
        i_dividend <= dvd;
        i_divisor  <= dvs;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and wait until every result has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        @(posedge i_clk);
    endtask

    // Operand mix: edge values, small magnitudes of both signs, full random
    function automatic logic [PORT_W-1:0] pick_operand();
        logic [PORT_W-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(10))
            0: v = '0;
            1: v = {{(PORT_W-1){1'b0}}, 1'b1};
            2: v = '1;
            3: v = {1'b1, {(PORT_W-1){1'b0}}};
            4: v = {1'b0, {(PORT_W-1){1'b1}}};
            5: v = PORT_W'($urandom_range(255));
            6: v = ~PORT_W'($urandom_range(1, 255)) + 1'b1;
            7: v = v >> $urandom_range(PORT_W - 1);
            8: v = $signed(v) >>> $urandom_range(PORT_W - 1);
            9: v = {{(PORT_W-1){1'b0}}, 1'b1} << $urandom_range(PORT_W - 1);
            default: ;
        endcase
        return v;
    endfunction

    task automatic run_random(input int count, input int tx_pct, input int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        repeat (count) begin
            send_item(2'($urandom_range(3)), pick_operand(), pick_operand());
        end
    endtask

    // Stimulus and verdict
    initial begin
        logic [PORT_W-1:0] min_neg;
        logic [PORT_W-1:0] max_pos;
        logic [PORT_W-1:0] minus_one;
        min_neg   = {1'b1, {(PORT_W-1){1'b0}}};
        max_pos   = ~min_neg;
        minus_one = '1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every op, zero divisor, most negative by minus one, signs
        send_item(REQ_UQUO, 100, 7);
        send_item(REQ_UQUO, minus_one, 1);
        send_item(REQ_UQUO, minus_one, 0);
        send_item(REQ_UQUO, 0, 5);
        send_item(REQ_UQUO, minus_one, minus_one);
        send_item(REQ_SQUO, -64'sd100, 7);
        send_item(REQ_SQUO, 100, -64'sd7);
        send_item(REQ_SQUO, -64'sd100, -64'sd7);
        send_item(REQ_SQUO, min_neg, minus_one);
        send_item(REQ_SQUO, min_neg, 1);
        send_item(REQ_SQUO, max_pos, min_neg);
        send_item(REQ_SQUO, min_neg, 0);
        send_item(REQ_UREM, 100, 7);
        send_item(REQ_UREM, minus_one, min_neg);
        send_item(REQ_UREM, max_pos, 0);
        send_item(REQ_UREM, 5, 10);
        send_item(REQ_SREM, -64'sd100, 7);
        send_item(REQ_SREM, 100, -64'sd7);
        send_item(REQ_SREM, min_neg, minus_one);
        send_item(REQ_SREM, -64'sd14, 7);
        send_item(REQ_SREM, minus_one, 0);
        send_item(REQ_SREM, min_neg, min_neg);
        send_item(REQ_SREM, max_pos, minus_one);

        run_random(PHASE_ITEMS, 0, 0);

        // Hold off results so the block backs up, then pause until empty
        hold_req <= ~hold_req;
        run_random(40, 0, 0);
        drain();

        run_random(PHASE_ITEMS, 50, 0);
        run_random(PHASE_ITEMS, 0, 50);
        run_random(PHASE_ITEMS, 36, 36);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("[divider_64bit_signed_unsigned_core] OK");
        end else begin
            $display("[divider_64bit_signed_unsigned_core] ERROR");
        end
        $finish;
    end

endmodule
